// ===== sv/kce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

    localparam int N_ELEMS_DEF    = 20;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 5;
    localparam int KEY_W    = 32;
    localparam int BLOCK_W  = 20;
    localparam int CIPHER_W = 37;
    localparam int CFG_W    = 32;
    localparam int CFG_IX_W = 2;
    localparam int ACC_W    = 37;
    localparam int MOD_W    = 33;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEC  = 2'd2;

    localparam logic [CFG_IX_W-1:0] REG_MODULUS    = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_INVERSE    = 2'd2;

    localparam logic RES_CIPHER = 1'b0;
    localparam logic RES_PLAIN  = 1'b1;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [MOD_W-1:0] t_mod;

    typedef enum logic [1:0] {
        OP_MSTEP,
        OP_SUBGE,
        OP_ADD
    } t_op;

    typedef struct packed {
        t_op  op;
        t_acc acc;
        t_acc operand;
    } t_alu_req;

    typedef struct packed {
        t_acc res;
        logic ge;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== sv/kce_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kce_in_if;
    import kce_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    elem_index;
    logic [KEY_W-1:0]    key_value;
    logic [BLOCK_W-1:0]  plain_block;
    logic [CIPHER_W-1:0] cipher_in;

    modport source (output valid, kind, elem_index, key_value, plain_block, cipher_in,
                    input ready);
    modport sink (input valid, kind, elem_index, key_value, plain_block, cipher_in,
                  output ready);
endinterface

interface kce_out_if;
    import kce_pkg::*;
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [CIPHER_W-1:0] cipher_out;
    logic [BLOCK_W-1:0]  plain_out;

    modport source (output valid, result_kind, cipher_out, plain_out, input ready);
    modport sink (input valid, result_kind, cipher_out, plain_out, output ready);
endinterface

interface kce_cfg_if;
    import kce_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_IX_W-1:0] index;
    logic [CFG_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/kce_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kce_alu (
    input  kce_pkg::t_alu_req i_req,
    input  kce_pkg::t_mod     i_modulus,
    output kce_pkg::t_alu_rsp o_rsp
);
    import kce_pkg::*;

    localparam int T_W = MOD_W + 2;

    logic [T_W-1:0] t;
    logic [T_W-1:0] m1;
    logic [T_W-1:0] m2;

    // modular step: (2*acc + operand) mod M, with acc and operand below M
    assign t  = {i_req.acc[T_W-2:0], 1'b0} + i_req.operand[T_W-1:0];
    assign m1 = {2'b00, i_modulus};
    assign m2 = {1'b0, i_modulus, 1'b0};

    always_comb begin
        o_rsp.res = i_req.acc;
        o_rsp.ge  = 1'b0;
        case (i_req.op)
            OP_MSTEP: begin
                if (t >= m2) begin
                    o_rsp.res = t_acc'(t - m2);
                end else if (t >= m1) begin
                    o_rsp.res = t_acc'(t - m1);
                end else begin
                    o_rsp.res = t_acc'(t);
                end
            end
            OP_SUBGE: begin
                o_rsp.ge = (i_req.acc >= i_req.operand);
                if (o_rsp.ge) begin
                    o_rsp.res = i_req.acc - i_req.operand;
                end
            end
            OP_ADD: begin
                o_rsp.res = i_req.acc + i_req.operand;
            end
            default: begin
                o_rsp.res = i_req.acc;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/kce_keystore.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kce_keystore #(
    parameter int N_ELEMS    = kce_pkg::N_ELEMS_DEF,
    parameter int ELEM_WIDTH = kce_pkg::ELEM_WIDTH_DEF,
    localparam int IW        = $clog2(N_ELEMS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_priv_we,
    input  wire logic [IW-1:0]         i_priv_waddr,
    input  wire logic [ELEM_WIDTH-1:0] i_priv_wdata,
    input  wire logic                  i_pub_we,
    input  wire logic [IW-1:0]         i_pub_waddr,
    input  wire logic [ELEM_WIDTH-1:0] i_pub_wdata,
    input  wire logic [IW-1:0]         i_raddr,
    output logic      [ELEM_WIDTH-1:0] o_priv,
    output logic      [ELEM_WIDTH-1:0] o_pub
);

    logic [ELEM_WIDTH-1:0] r_priv_mem [N_ELEMS];
    logic [ELEM_WIDTH-1:0] r_pub_mem  [N_ELEMS];

    always_ff @(posedge i_clk) begin
        if (i_priv_we) begin
            r_priv_mem[i_priv_waddr] <= i_priv_wdata;
        end
        o_priv <= r_priv_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_pub_we) begin
            r_pub_mem[i_pub_waddr] <= i_pub_wdata;
        end
        o_pub <= r_pub_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/knapsack_cipher_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Port   Dir  Carries
// input    i_in   in   kind, elem_index, key_value, plain_block, cipher_in
// result   o_out  out  result_kind, cipher_out, plain_out
// config   i_cfg  in   index, data (modulus, multiplier, inverse_mult)
//
// Encrypt and decrypt each end in a result; a load holds the input off while it
// runs and gives no result. The bit-serial modular step unit takes one operand
// bit a cycle, and one key element is read a cycle. Input ready only while idle;
// a pending result stalls the next finish only. Synchronous active-low reset;
// key store is not cleared.

module knapsack_cipher_engine_core #(
    parameter int N_ELEMS    = kce_pkg::N_ELEMS_DEF,
    parameter int ELEM_WIDTH = kce_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kce_in_if.sink     i_in,
    kce_out_if.source  o_out,
    kce_cfg_if.sink    i_cfg
);
    import kce_pkg::*;

    localparam int IW = $clog2(N_ELEMS);
    localparam int PW = (N_ELEMS > BLOCK_W) ? N_ELEMS : BLOCK_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_GRD  = 3'd3;
    localparam logic [2:0] ST_ENC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]          r_state;
    logic [KIND_W-1:0]   r_kind;
    logic [5:0]          r_cnt;
    logic [IW-1:0]       r_idx;
    t_acc                r_a;
    t_acc                r_acc;
    logic [KEY_W-1:0]    r_ar;
    logic [PW-1:0]       r_bits;
    logic [CFG_W-1:0]    r_mod;
    logic [CFG_W-1:0]    r_mult;
    logic [CFG_W-1:0]    r_inv;
    logic                r_ov;
    logic                r_out_kind;
    logic [CIPHER_W-1:0] r_out_cipher;
    logic [BLOCK_W-1:0]  r_out_plain;

    logic                  accept;
    logic                  idx_ok;
    logic                  last;
    t_mod                  modulus;
    t_alu_req              req;
    t_alu_rsp              rsp;
    logic [IW-1:0]         raddr;
    logic                  pub_we;
    logic [ELEM_WIDTH-1:0] rd_priv;
    logic [ELEM_WIDTH-1:0] rd_pub;
    logic [KEY_W-1:0]      key_m;

    assign accept  = i_in.valid && i_in.ready;
    assign idx_ok  = (i_in.elem_index < IDX_W'(N_ELEMS));
    assign last    = (r_cnt == 6'd0);
    assign modulus = (r_mod == '0) ? {1'b1, {CFG_W{1'b0}}} : {1'b0, r_mod};
    assign key_m   = KEY_W'(i_in.key_value[ELEM_WIDTH-1:0]);
    assign pub_we  = (r_state == ST_MUL) && last && (r_kind == KIND_LOAD);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_ov;
    assign o_out.result_kind = r_out_kind;
    assign o_out.cipher_out  = r_out_cipher;
    assign o_out.plain_out   = r_out_plain;

    always_comb begin
        req.op      = OP_MSTEP;
        req.acc     = r_acc;
        req.operand = '0;
        case (r_state)
            ST_RED: begin
                req.op      = OP_MSTEP;
                req.operand = t_acc'(r_a[ACC_W-1]);
            end
            ST_MUL: begin
                req.op      = OP_MSTEP;
                req.operand = r_a[ACC_W-1] ? t_acc'(r_ar) : '0;
            end
            ST_GRD: begin
                req.op      = OP_SUBGE;
                req.operand = t_acc'(rd_priv);
            end
            ST_ENC: begin
                req.op      = OP_ADD;
                req.operand = r_a[0] ? t_acc'(rd_pub) : '0;
            end
            default: begin
                req.op      = OP_MSTEP;
                req.operand = '0;
            end
        endcase
    end

    // read address leads the element in use by one element, as the key store read is registered
    always_comb begin
        case (r_state)
            ST_ENC:  raddr = (r_cnt[IW-1:0] == IW'(N_ELEMS - 1)) ?
                             r_cnt[IW-1:0] : r_cnt[IW-1:0] + IW'(1);
            ST_GRD:  raddr = last ? '0 : r_cnt[IW-1:0] - IW'(1);
            ST_MUL:  raddr = IW'(N_ELEMS - 1);
            default: raddr = '0;
        endcase
    end

    kce_alu u_alu (
        .i_req     (req),
        .i_modulus (modulus),
        .o_rsp     (rsp)
    );

    kce_keystore #(
        .N_ELEMS    (N_ELEMS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_keystore (
        .i_clk        (i_clk),
        .i_priv_we    (accept && (i_in.kind == KIND_LOAD) && idx_ok),
        .i_priv_waddr (i_in.elem_index[IW-1:0]),
        .i_priv_wdata (i_in.key_value[ELEM_WIDTH-1:0]),
        .i_pub_we     (pub_we),
        .i_pub_waddr  (r_idx),
        .i_pub_wdata  (rsp.res[ELEM_WIDTH-1:0]),
        .i_raddr      (raddr),
        .o_priv       (rd_priv),
        .o_pub        (rd_pub)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= CFG_W'(2);
            r_mult <= CFG_W'(1);
            r_inv  <= CFG_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODULUS:    r_mod  <= i_cfg.data;
                REG_MULTIPLIER: r_mult <= i_cfg.data;
                REG_INVERSE:    r_inv  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // in ST_FIN the finish logic below owns r_ov
            if (r_ov && o_out.ready && (r_state != ST_FIN)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_kind <= i_in.kind;
                        r_acc  <= '0;
                        case (i_in.kind)
                            KIND_LOAD: begin
                                if (idx_ok) begin
                                    r_idx   <= i_in.elem_index[IW-1:0];
                                    r_a     <= {key_m, 5'b0};
                                    r_cnt   <= 6'd31;
                                    r_state <= ST_RED;
                                end
                            end
                            KIND_ENC: begin
                                r_a     <= t_acc'(i_in.plain_block);
                                r_cnt   <= '0;
                                r_state <= ST_ENC;
                            end
                            KIND_DEC: begin
                                r_a     <= i_in.cipher_in;
                                r_cnt   <= 6'(CIPHER_W - 1);
                                r_state <= ST_RED;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RED: begin
                    if (last) begin
                        r_ar    <= rsp.res[KEY_W-1:0];
                        r_acc   <= '0;
                        r_a     <= {(r_kind == KIND_LOAD) ? r_mult : r_inv, 5'b0};
                        r_cnt   <= 6'd31;
                        r_state <= ST_MUL;
                    end else begin
                        r_acc <= rsp.res;
                        r_a   <= r_a << 1;
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_MUL: begin
                    r_acc <= rsp.res;
                    r_a   <= r_a << 1;
                    if (last) begin
                        if (r_kind == KIND_LOAD) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_bits  <= '0;
                            r_cnt   <= 6'(N_ELEMS - 1);
                            r_state <= ST_GRD;
                        end
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_GRD: begin
                    r_acc  <= rsp.res;
                    r_bits <= {r_bits[PW-2:0], rsp.ge};
                    if (last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_ENC: begin
                    r_acc <= rsp.res;
                    r_a   <= r_a >> 1;
                    if (r_cnt == 6'(N_ELEMS - 1)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        if (r_kind == KIND_DEC) begin
                            r_out_kind   <= RES_PLAIN;
                            r_out_cipher <= '0;
                            r_out_plain  <= r_bits[BLOCK_W-1:0];
                        end else begin
                            r_out_kind   <= RES_CIPHER;
                            r_out_cipher <= r_acc;
                            r_out_plain  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
